FILE: src/sns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sns_pkg
// Shared widths, register indexes, mode codes and constants of the spectral
// noise subtraction block.
// ----------------------------------------------------------------------------
package sns_pkg;

   localparam int SNS_BIN_COUNT = 257;
   localparam int SNS_NUM_AXES  = 3;

   // payload widths
   localparam int AXIS_W  = 2;
   localparam int BIN_W   = 9;
   localparam int POWER_W = 32;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_TARGET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_RATE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_LEARN  = 3'd4;

   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_FIXED = 2'd1;
   localparam logic [1:0] MODE_ADAPT = 2'd2;

   localparam logic [15:0] GAIN_RESET  = 16'd4096;
   localparam logic [15:0] FORCED_RATE = 16'd13107;  // 0.2 in q0.16
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [15:0] Q16_HALF    = 16'h8000;
   localparam logic [16:0] Q16_ONE     = 17'h10000;

   // shared arithmetic unit
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 17;
   localparam int ACC_W   = MUL_A_W + MUL_B_W;
   localparam int GAIN_FRAC = 12;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage : sns_pkg
`default_nettype wire

FILE: src/sns_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sns_req_if / sns_rsp_if
// Valid/ready channels for power bins in and cleaned bins out.
// ----------------------------------------------------------------------------
interface sns_req_if import sns_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [AXIS_W-1:0]  axis_sel;
   logic [BIN_W-1:0]   bin_number;
   logic [POWER_W-1:0] bin_power;
   logic               frame_end;

   modport source (output valid, axis_sel, bin_number, bin_power, frame_end,
                   input ready);
   modport sink   (input valid, axis_sel, bin_number, bin_power, frame_end,
                   output ready);
endinterface : sns_req_if

interface sns_rsp_if import sns_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POWER_W-1:0] clean_power;
   logic [POWER_W-1:0] noise_level;

   modport source (output valid, clean_power, noise_level, input ready);
   modport sink   (input valid, clean_power, noise_level, output ready);
endinterface : sns_rsp_if
`default_nettype wire

FILE: src/sns_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sns_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sns_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : sns_ram
`default_nettype wire

FILE: src/spectral_noise_subtraction.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_noise_subtraction
// Per-bin noise profile learning and spectral subtraction on power bins.
// ----------------------------------------------------------------------------
// One power bin is taken at a time. After reset the block first zeroes all
// NUM_AXES*BIN_COUNT entries (771 at the defaults) of the noise profile RAM,
// one entry per cycle, and takes no bin until that is done; configuration
// writes are taken at any time. A bin has its profile entry read if its
// axis and bin are in range; one out of range or with mode off is passed
// through. Learning runs two multiply and accumulate steps in adaptive mode,
// or one and then the running mean in fixed mode, which divides by count+1
// one quotient bit per cycle; a subtracted bin then takes a gain multiply
// and a subtract. One 32x17 multiplier and one 49-bit adder are reused step
// by step. A finished result sits in an output register, so the next bin
// may be taken while it waits; a result that finds that register still full
// holds the block in its last step until the waiting beat is taken.
// ----------------------------------------------------------------------------
module spectral_noise_subtraction
   import sns_pkg::*;
#(
   parameter int BIN_COUNT = SNS_BIN_COUNT,
   parameter int NUM_AXES  = SNS_NUM_AXES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   sns_req_if.sink                    req,
   sns_rsp_if.source                  rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOTS   = NUM_AXES * BIN_COUNT;
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int AXIS_IW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_ADDR, ST_LOAD, ST_MUL1, ST_ACC1, ST_MUL2,
      ST_ACC2, ST_DIV, ST_FIN, ST_GMUL, ST_GSUB, ST_DONE
   } state_type;

   // configuration registers
   logic [1:0]  noise_mode_ff;
   logic [15:0] learn_target_ff;
   logic [15:0] adapt_rate_ff;
   logic [15:0] sub_gain_ff;
   logic        force_learn_ff;

   // sequencer state
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clear_cnt_ff, clear_cnt_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [15:0]        frames_ff [NUM_AXES];
   logic [15:0]        frames_in [NUM_AXES];

   // item and work registers
   logic [AXIS_W-1:0]  axis_ff, axis_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [POWER_W-1:0] power_ff, power_in;
   logic               last_ff, last_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic [15:0]        count_ff, count_in;
   logic [15:0]        after_ff, after_in;
   logic               learning_ff, learning_in;
   logic               subtract_ff, subtract_in;
   logic [POWER_W-1:0] noise_ff, noise_in;
   logic [POWER_W-1:0] clean_ff, clean_in;
   logic [ACC_W-1:0]   prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [15:0]        rem_ff, rem_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POWER_W-1:0] rsp_clean_ff, rsp_clean_in;
   logic [POWER_W-1:0] rsp_noise_ff, rsp_noise_in;

   // shared arithmetic
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [ACC_W-1:0]   mul_res;
   logic [ACC_W-1:0]   add_x, add_y;
   logic               add_sub;
   logic [ACC_W:0]     add_res;

   // memory port
   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [POWER_W-1:0] ram_wdata, ram_rdata;

   // helpers
   logic [AXIS_IW-1:0] axis_no;
   logic               in_range;
   logic [ADDR_W-1:0]  slot_calc;
   logic [15:0]        count_now;
   logic               learn_now;
   logic [15:0]        after_now;
   logic [15:0]        rate_sel;
   logic [16:0]        divisor;
   logic [16:0]        rem_sh;
   logic               div_ge;
   logic [POWER_W-1:0] diff_q;
   logic               is_adapt;

   assign axis_no   = axis_ff[AXIS_IW-1:0];
   assign in_range  = (32'(axis_ff) < 32'(NUM_AXES)) && (32'(bin_ff) < 32'(BIN_COUNT));
   assign slot_calc = ADDR_W'(ADDR_W'(axis_no) * ADDR_W'(BIN_COUNT) + ADDR_W'(bin_ff));
   assign is_adapt  = (noise_mode_ff == MODE_ADAPT);
   assign rate_sel  = force_learn_ff ? FORCED_RATE : adapt_rate_ff;
   assign count_now = frames_ff[axis_no];
   assign learn_now = force_learn_ff || (count_now < learn_target_ff);
   assign after_now = (learn_now && (count_now != COUNT_MAX)) ? count_now + 16'd1
                                                              : count_now;
   assign divisor   = 17'(count_ff) + 17'd1;
   assign rem_sh    = {rem_ff, acc_ff[31]};
   assign div_ge    = add_res[ACC_W];
   assign diff_q    = add_res[GAIN_FRAC +: POWER_W];

   assign mul_res = ACC_W'(mul_a) * ACC_W'(mul_b);
   assign add_res = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                    + (ACC_W + 1)'(add_sub);

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.clean_power = rsp_clean_ff;
   assign rsp.noise_level = rsp_noise_ff;

   sns_ram #(
      .WIDTH  (POWER_W),
      .DEPTH  (SLOTS),
      .ADDR_W (ADDR_W)
   ) u_profile (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // operand selection for the shared multiplier and adder
   always_comb begin
      mul_a   = noise_ff;
      mul_b   = {1'b0, sub_gain_ff};
      add_x   = prod_ff;
      add_y   = ACC_W'(power_ff);
      add_sub = 1'b0;
      case (state_ff)
         ST_MUL1: begin
            mul_b = is_adapt ? (Q16_ONE - 17'(rate_sel)) : 17'(count_ff);
         end
         ST_MUL2: begin
            mul_a = power_ff;
            mul_b = 17'(rate_sel);
         end
         ST_ACC1: begin
            if (is_adapt) begin
               add_y = ACC_W'(Q16_HALF);
            end
         end
         ST_ACC2: begin
            add_x = acc_ff;
            add_y = prod_ff;
         end
         ST_DIV: begin
            add_x   = ACC_W'(rem_sh);
            add_y   = ACC_W'(divisor);
            add_sub = 1'b1;
         end
         ST_GSUB: begin
            add_x   = ACC_W'({power_ff, {GAIN_FRAC{1'b0}}});
            add_y   = prod_ff;
            add_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      frames_in    = frames_ff;
      axis_in      = axis_ff;
      bin_in       = bin_ff;
      power_in     = power_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      after_in     = after_ff;
      learning_in  = learning_ff;
      subtract_in  = subtract_ff;
      noise_in     = noise_ff;
      clean_in     = clean_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_clean_in = rsp_clean_ff;
      rsp_noise_in = rsp_noise_ff;
      ram_we       = 1'b0;
      ram_waddr    = slot_ff;
      ram_wdata    = noise_ff;
      ram_re       = 1'b0;
      ram_raddr    = slot_calc;

      case (state_ff)
         ST_CLEAR: begin
            ram_we       = 1'b1;
            ram_waddr    = clear_cnt_ff;
            ram_wdata    = '0;
            clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
            if (clear_cnt_ff == ADDR_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               axis_in  = req.axis_sel;
               bin_in   = req.bin_number;
               power_in = req.bin_power;
               last_in  = req.frame_end;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            slot_in = slot_calc;
            if (in_range) begin
               ram_re   = 1'b1;
               state_in = ST_LOAD;
            end else begin
               clean_in = power_ff;
               noise_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_LOAD: begin
            noise_in    = ram_rdata;
            count_in    = count_now;
            learning_in = learn_now;
            after_in    = after_now;
            subtract_in = is_adapt || (after_now >= learn_target_ff);
            if (noise_mode_ff != MODE_FIXED && noise_mode_ff != MODE_ADAPT) begin
               clean_in = power_ff;
               state_in = ST_DONE;
            end else if (learn_now) begin
               state_in = ST_MUL1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MUL1: begin
            prod_in  = mul_res;
            state_in = ST_ACC1;
         end
         ST_ACC1: begin
            acc_in = add_res[ACC_W-1:0];
            if (is_adapt) begin
               state_in = ST_MUL2;
            end else begin
               // quotient fits 32 bits, so the top part starts as remainder
               rem_in     = add_res[47:32];
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_MUL2: begin
            prod_in  = mul_res;
            state_in = ST_ACC2;
         end
         ST_ACC2: begin
            noise_in = add_res[47:16];
            state_in = ST_FIN;
         end
         ST_DIV: begin
            rem_in     = div_ge ? add_res[15:0] : rem_sh[15:0];
            acc_in     = {acc_ff[ACC_W-1:32], acc_ff[30:0], div_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               noise_in = {acc_ff[30:0], div_ge};
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            ram_we = learning_ff;
            if (last_ff && learning_ff) begin
               frames_in[axis_no] = after_ff;
            end
            if (subtract_ff) begin
               state_in = ST_GMUL;
            end else begin
               clean_in = power_ff;
               state_in = ST_DONE;
            end
         end
         ST_GMUL: begin
            prod_in  = mul_res;
            state_in = ST_GSUB;
         end
         ST_GSUB: begin
            // borrow or a zero quotient both floor at one lsb
            if (!add_res[ACC_W] || diff_q == '0) begin
               clean_in = POWER_W'(1);
            end else begin
               clean_in = diff_q;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_clean_in = clean_ff;
               rsp_noise_in = noise_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            frames_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         frames_ff    <= frames_in;
      end
      div_cnt_ff   <= div_cnt_in;
      axis_ff      <= axis_in;
      bin_ff       <= bin_in;
      power_ff     <= power_in;
      last_ff      <= last_in;
      slot_ff      <= slot_in;
      count_ff     <= count_in;
      after_ff     <= after_in;
      learning_ff  <= learning_in;
      subtract_ff  <= subtract_in;
      noise_ff     <= noise_in;
      clean_ff     <= clean_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      rsp_clean_ff <= rsp_clean_in;
      rsp_noise_ff <= rsp_noise_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_mode_ff   <= MODE_OFF;
         learn_target_ff <= '0;
         adapt_rate_ff   <= '0;
         sub_gain_ff     <= GAIN_RESET;
         force_learn_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NOISE_MODE:   noise_mode_ff   <= csr_wdata[1:0];
            CSR_LEARN_TARGET: learn_target_ff <= csr_wdata;
            CSR_ADAPT_RATE:   adapt_rate_ff   <= csr_wdata;
            CSR_SUB_GAIN:     sub_gain_ff     <= csr_wdata;
            CSR_FORCE_LEARN:  force_learn_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule : spectral_noise_subtraction
`default_nettype wire
